FILE: sv/cslt_pkg.sv
// ----------------------------------------------------------------------------
// cslt_pkg
// Shared types and constants of the call stack latency tracker.
// ----------------------------------------------------------------------------
package cslt_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int STACK_SLOTS  = 32;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int DEPTH_W      = $clog2(STACK_SLOTS);
    localparam int ADDR_W       = SLOT_W + DEPTH_W;
    localparam int FRAMES       = THREAD_SLOTS * STACK_SLOTS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DEPTH_W-1:0] FRAME_CAP = DEPTH_W'(STACK_SLOTS - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    localparam logic MODE_ENTRY  = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED   = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_MATCHED  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_PUSH,
        K_OVERFLOW,
        K_EMPTY,
        K_POP
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic        mode;
        logic [3:0]  thread_slot;
        logic [63:0] func_id;
        logic [30:0] line_number;
        logic [63:0] timestamp;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [4:0]  stack_depth;
        logic [63:0] pop_delay;
        logic [63:0] worst_func_id;
        logic [30:0] worst_line;
        logic [63:0] worst_delay;
    } t_out;

    // Classified transaction handed from the front end to the back end.
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [DEPTH_W-1:0] depth;
        logic [ADDR_W-1:0]  addr;
        logic [63:0]        func_id;
        logic [30:0]        line;
        logic [63:0]        timestamp;
    } t_op;

    typedef struct packed {
        logic [63:0] func_id;
        logic [30:0] line;
        logic [63:0] timestamp;
    } t_frame;

    // Completion report from the back end: new depth of one stack.
    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [DEPTH_W-1:0] depth;
    } t_done;

endpackage

FILE: sv/cslt_fifo.sv
// ----------------------------------------------------------------------------
// cslt_fifo
// Short queue of classified transactions between the front and back ends.
// ----------------------------------------------------------------------------
module cslt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cslt_pkg::t_op   i_data,
    input  logic            i_pop,
    output cslt_pkg::t_op   o_head,
    output logic            o_empty,
    output logic            o_full
);

    cslt_pkg::t_op                    r_mem [cslt_pkg::QUEUE_DEPTH];
    logic [cslt_pkg::QPTR_W-1:0]      r_wp;
    logic [cslt_pkg::QPTR_W-1:0]      r_rp;
    logic [cslt_pkg::QCNT_W-1:0]      r_cnt;
    logic [cslt_pkg::QPTR_W-1:0]      n_wp;
    logic [cslt_pkg::QPTR_W-1:0]      n_rp;
    logic [cslt_pkg::QCNT_W-1:0]      n_cnt;
    logic                             do_push;
    logic                             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == cslt_pkg::QCNT_W'(cslt_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == cslt_pkg::QPTR_W'(cslt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == cslt_pkg::QPTR_W'(cslt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: sv/cslt_front.sv
// ----------------------------------------------------------------------------
// cslt_front
// Accepts events, looks up the stack depth of the slot and classifies each
// event before queuing it for the back end.
// ----------------------------------------------------------------------------
module cslt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  cslt_pkg::t_in   i_item,
    output logic            busy,
    input  logic            i_q_full,
    output logic            o_q_push,
    output cslt_pkg::t_op   o_q_data,
    input  cslt_pkg::t_done i_done
);

    logic [cslt_pkg::DEPTH_W-1:0] r_count [cslt_pkg::THREAD_SLOTS];
    logic                         r_pending;
    logic                         accept;
    logic [cslt_pkg::SLOT_W-1:0]  slot;
    logic [cslt_pkg::DEPTH_W-1:0] depth;
    logic [cslt_pkg::DEPTH_W-1:0] index;

    assign busy     = r_pending || i_q_full;
    assign accept   = start && !busy;
    assign o_q_push = accept;
    assign slot     = i_item.thread_slot;
    assign depth    = r_count[slot];

    always_comb begin
        o_q_data           = '0;
        o_q_data.slot      = slot;
        o_q_data.depth     = depth;
        o_q_data.func_id   = i_item.func_id;
        o_q_data.line      = i_item.line_number;
        o_q_data.timestamp = i_item.timestamp;
        index              = depth;
        if (i_item.mode == cslt_pkg::MODE_ENTRY) begin
            o_q_data.kind = (depth == cslt_pkg::FRAME_CAP) ? cslt_pkg::K_OVERFLOW
                                                           : cslt_pkg::K_PUSH;
        end else begin
            // A return looks at the top frame, one below the depth.
            index         = depth - cslt_pkg::DEPTH_ONE;
            o_q_data.kind = (depth == '0) ? cslt_pkg::K_EMPTY : cslt_pkg::K_POP;
        end
        o_q_data.addr = {slot, index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            for (int i = 0; i < cslt_pkg::THREAD_SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_pending <= 1'b1;
            end else if (i_done.valid) begin
                r_pending <= 1'b0;
            end
            if (i_done.valid) begin
                r_count[i_done.slot] <= i_done.depth;
            end
        end
    end

endmodule

FILE: sv/cslt_back.sv
// ----------------------------------------------------------------------------
// cslt_back
// Executes queued transactions: frame memory access, id check, delay
// computation and the per-slot worst-delay record.
// ----------------------------------------------------------------------------
module cslt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  cslt_pkg::t_op     i_q_head,
    output logic              o_q_pop,
    output cslt_pkg::t_done   o_done_info,
    output logic              o_done,
    output cslt_pkg::t_out    o_result
);

    cslt_pkg::t_frame       r_frames [cslt_pkg::FRAMES];
    cslt_pkg::t_frame       r_rd;
    cslt_pkg::t_op          r_op;
    cslt_pkg::t_back_state  r_state;
    cslt_pkg::t_back_state  n_state;
    logic                   r_match;
    logic [63:0]            r_delay;
    logic [63:0]            r_wfunc  [cslt_pkg::THREAD_SLOTS];
    logic [30:0]            r_wline  [cslt_pkg::THREAD_SLOTS];
    logic [63:0]            r_wdelay [cslt_pkg::THREAD_SLOTS];
    logic                   r_valid;
    cslt_pkg::t_out         r_res;
    cslt_pkg::t_done        r_done;

    logic                   mem_we;
    logic                   finish;
    logic                   upd;
    cslt_pkg::t_out         n_res;
    cslt_pkg::t_frame       wr_frame;

    assign o_done      = r_valid;
    assign o_result    = r_res;
    assign o_done_info = r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cslt_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = cslt_pkg::BK_EXEC;
                end
            end
            cslt_pkg::BK_EXEC: n_state = cslt_pkg::BK_DONE;
            cslt_pkg::BK_DONE: n_state = cslt_pkg::BK_IDLE;
            default:           n_state = cslt_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        finish  = 1'b0;
        unique case (r_state)
            cslt_pkg::BK_IDLE: o_q_pop = !i_q_empty;
            cslt_pkg::BK_EXEC: ;
            cslt_pkg::BK_DONE: finish = 1'b1;
            default:           ;
        endcase
    end

    assign mem_we             = o_q_pop && (i_q_head.kind == cslt_pkg::K_PUSH);
    assign wr_frame.func_id   = i_q_head.func_id;
    assign wr_frame.line      = i_q_head.line;
    assign wr_frame.timestamp = i_q_head.timestamp;

    // Frame store: a write for a push, and a registered read for every transaction.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frames[i_q_head.addr] <= wr_frame;
        end
        if (o_q_pop) begin
            r_rd <= r_frames[i_q_head.addr];
            r_op <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cslt_pkg::BK_EXEC) begin
            r_match <= (r_rd.func_id == r_op.func_id);
            r_delay <= r_op.timestamp - r_rd.timestamp;
        end
    end

    always_comb begin
        upd               = 1'b0;
        n_res             = '0;
        n_res.stack_depth = r_op.depth;
        case (r_op.kind)
            cslt_pkg::K_PUSH: begin
                n_res.status      = cslt_pkg::ST_PUSHED;
                n_res.stack_depth = r_op.depth + cslt_pkg::DEPTH_ONE;
            end
            cslt_pkg::K_OVERFLOW: n_res.status = cslt_pkg::ST_OVERFLOW;
            cslt_pkg::K_EMPTY:    n_res.status = cslt_pkg::ST_EMPTY;
            cslt_pkg::K_POP: begin
                if (r_match) begin
                    n_res.status      = cslt_pkg::ST_MATCHED;
                    n_res.stack_depth = r_op.depth - cslt_pkg::DEPTH_ONE;
                    n_res.pop_delay   = r_delay;
                    upd               = (r_delay > r_wdelay[r_op.slot]);
                end else begin
                    n_res.status = cslt_pkg::ST_MISMATCH;
                end
            end
            default: n_res.status = cslt_pkg::ST_EMPTY;
        endcase
        if (upd) begin
            n_res.worst_func_id = r_rd.func_id;
            n_res.worst_line    = r_rd.line;
            n_res.worst_delay   = r_delay;
        end else begin
            n_res.worst_func_id = r_wfunc[r_op.slot];
            n_res.worst_line    = r_wline[r_op.slot];
            n_res.worst_delay   = r_wdelay[r_op.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cslt_pkg::BK_IDLE;
            r_valid <= 1'b0;
            r_done  <= '0;
            for (int i = 0; i < cslt_pkg::THREAD_SLOTS; i++) begin
                r_wfunc[i]  <= '0;
                r_wline[i]  <= '0;
                r_wdelay[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_valid      <= finish;
            r_done.valid <= finish;
            r_done.slot  <= r_op.slot;
            r_done.depth <= n_res.stack_depth;
            if (finish && upd) begin
                r_wfunc[r_op.slot]  <= r_rd.func_id;
                r_wline[r_op.slot]  <= r_rd.line;
                r_wdelay[r_op.slot] <= r_delay;
            end
        end
    end

endmodule

FILE: sv/call_stack_latency_tracker.sv
// ----------------------------------------------------------------------------
// call_stack_latency_tracker
// Per-thread shadow call stacks with worst return-delay tracking.
// ----------------------------------------------------------------------------
// Each event passes the queue, the frame memory read, the delay subtract with
// the id check, then the record compare; o_done and the result are registered
// together, and a new event is taken only after busy drops.
// busy stays high from acceptance until the stack depth is written back.
// Reset clears every stack depth and worst record at once; frames need none.
// The receiver cannot stall: each result is shown for exactly one cycle.
module call_stack_latency_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  cslt_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_done,
    output cslt_pkg::t_out o_result
);

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    cslt_pkg::t_op   q_data;
    cslt_pkg::t_op   q_head;
    cslt_pkg::t_done done_info;

    cslt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_data),
        .i_done   (done_info)
    );

    cslt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cslt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_done_info (done_info),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
